/* rtl/assert_macros.svh */
// assertion macros shared by the stack engine rtl
// depends on: nothing; users must have clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

/* rtl/msec_pkg.sv */
// shared types and constants of the multi stack engine
// depends on: nothing
`timescale 1ns / 1ps
package msec_pkg;
	localparam int NUM_STACKS_DEF  = 16;
	localparam int MAX_DEPTH_DEF   = 64;
	localparam int VALUE_WIDTH_DEF = 64;

	localparam int ID_W        = 4;
	localparam int DATA_W      = 64;
	localparam int CAP_W       = 8;
	localparam int FILL_OUT_W  = 7;
	localparam int CMD_W       = 2;
	localparam int STATUS_W    = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 80;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC,
		CMD_PUSH,
		CMD_POP,
		CMD_QUERY
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_NO_FREE,
		ST_FULL,
		ST_EMPTY,
		ST_NOT_ALLOC
	} status_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [ID_W-1:0]   id;
		logic [DATA_W-1:0] value;
		logic [CAP_W-1:0]  cap;
	} item_t;
endpackage

/* rtl/msec_front.sv */
// front stage: takes requests, decodes the command and saturates the capacity
// depends on: msec_pkg
`timescale 1ns / 1ps
module msec_front #(
	parameter int MAX_DEPTH = msec_pkg::MAX_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [msec_pkg::S_TDATA_W-1:0] s_axis_tdata, // stack_id, push_value, capacity
	input  logic [msec_pkg::CMD_W-1:0]     s_axis_tuser, // cmd
	output logic                           q_valid,
	input  logic                           q_ready,
	output msec_pkg::item_t                q_item
);
	localparam int VAL_LSB = msec_pkg::ID_W;
	localparam int CAP_LSB = VAL_LSB + msec_pkg::DATA_W;
	localparam logic [msec_pkg::CAP_W-1:0] CAP_MAX = msec_pkg::CAP_W'(MAX_DEPTH);

	logic                          valid_s1;
	msec_pkg::item_t               item_s1;
	msec_pkg::item_t               item_d;
	logic [msec_pkg::CAP_W-1:0]    cap_in;

	always_comb begin
		cap_in       = s_axis_tdata[CAP_LSB +: msec_pkg::CAP_W];
		item_d.cmd   = msec_pkg::cmd_t'(s_axis_tuser);
		item_d.id    = s_axis_tdata[0 +: msec_pkg::ID_W];
		item_d.value = s_axis_tdata[VAL_LSB +: msec_pkg::DATA_W];
		// capacity saturates at the per-stack region size
		item_d.cap   = (cap_in > CAP_MAX) ? CAP_MAX : cap_in;
	end

	assign s_axis_tready = !valid_s1 || q_ready;
	assign q_valid       = valid_s1;
	assign q_item        = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= item_d;
		end
	end
endmodule

/* rtl/msec_queue.sv */
// short request queue between the front and back stages
// depends on: msec_pkg
`timescale 1ns / 1ps
module msec_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  msec_pkg::item_t in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output msec_pkg::item_t out_item
);
	localparam int PTR_W = (msec_pkg::QUEUE_DEPTH > 1) ? $clog2(msec_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(msec_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(msec_pkg::QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(msec_pkg::QUEUE_DEPTH);

	msec_pkg::item_t  entries_q [msec_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign in_ready  = (count_q != CNT_FULL);
	assign out_valid = (count_q != '0);
	assign out_item  = entries_q[rd_ptr_q];
	assign do_wr     = in_valid && in_ready;
	assign do_rd     = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= in_item;
		end
	end
endmodule

/* rtl/msec_back.sv */
// back stage: sequencer over the fill, limit and entry memories, output register
// depends on: msec_pkg
`timescale 1ns / 1ps
module msec_back #(
	parameter int NUM_STACKS  = msec_pkg::NUM_STACKS_DEF,
	parameter int MAX_DEPTH   = msec_pkg::MAX_DEPTH_DEF,
	parameter int VALUE_WIDTH = msec_pkg::VALUE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	output logic                           q_ready,
	input  msec_pkg::item_t                q_item,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [msec_pkg::M_TDATA_W-1:0] m_axis_tdata, // result_id, pop_value, fill_level, is_empty
	output logic [msec_pkg::STATUS_W-1:0]  m_axis_tuser  // status
);
	localparam int STK_W       = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam int CNT_W       = $clog2(NUM_STACKS + 1);
	localparam int FILL_W      = $clog2(MAX_DEPTH + 1);
	localparam int STORE_DEPTH = NUM_STACKS * MAX_DEPTH;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int M_PAD       = msec_pkg::M_TDATA_W
		- (msec_pkg::ID_W + msec_pkg::DATA_W + msec_pkg::FILL_OUT_W + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_STACKS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_POP
	} state_t;

	state_t                         state_q;
	msec_pkg::item_t                cur_q;
	logic [CNT_W-1:0]               alloc_q;
	logic [FILL_W-1:0]              fill_rd_q;
	logic [FILL_W-1:0]              lim_rd_q;
	logic [VALUE_WIDTH-1:0]         ent_rd_q;

	logic                           out_valid_q;
	msec_pkg::status_t              out_status_q;
	logic [msec_pkg::ID_W-1:0]      out_id_q;
	logic [msec_pkg::DATA_W-1:0]    out_pop_q;
	logic [msec_pkg::FILL_OUT_W-1:0] out_fill_q;
	logic                           out_empty_q;

	logic [FILL_W-1:0]              fill_mem [NUM_STACKS];
	logic [FILL_W-1:0]              lim_mem  [NUM_STACKS];
	logic [VALUE_WIDTH-1:0]         ent_mem  [STORE_DEPTH];

	logic                           out_free;
	logic                           start;
	logic [STK_W-1:0]               rd_idx;
	logic [STK_W-1:0]               cur_idx;
	logic [STK_W-1:0]               alloc_idx;
	logic                           id_ok;
	logic [ADDR_W-1:0]              base;
	logic [ADDR_W-1:0]              addr_push;
	logic [ADDR_W-1:0]              addr_pop;
	logic [FILL_W-1:0]              fill_inc;
	logic [FILL_W-1:0]              fill_dec;

	msec_pkg::status_t              nx_status;
	logic [msec_pkg::ID_W-1:0]      nx_id;
	logic [FILL_W-1:0]              nx_fill;
	logic                           nx_empty;
	logic                           fill_we;
	logic [STK_W-1:0]               fill_waddr;
	logic [FILL_W-1:0]              fill_wdata;
	logic                           lim_we;
	logic                           ent_we;
	logic                           ent_re;
	logic                           alloc_inc;

	assign out_free  = !out_valid_q || m_axis_tready;
	assign start     = (state_q == S_IDLE) && q_valid && out_free;
	assign q_ready   = start;
	assign rd_idx    = STK_W'(q_item.id);
	assign cur_idx   = STK_W'(cur_q.id);
	assign alloc_idx = STK_W'(alloc_q);
	assign id_ok     = (32'(cur_q.id) < 32'(alloc_q));
	assign base      = ADDR_W'(32'(cur_idx) * MAX_DEPTH);
	assign fill_inc  = fill_rd_q + 1'b1;
	assign fill_dec  = fill_rd_q - 1'b1;
	assign addr_push = base + ADDR_W'(fill_rd_q);
	assign addr_pop  = base + ADDR_W'(fill_dec);

	always_comb begin
		nx_status  = msec_pkg::ST_OK;
		nx_id      = cur_q.id;
		nx_fill    = fill_rd_q;
		nx_empty   = (fill_rd_q == '0);
		fill_we    = 1'b0;
		fill_waddr = cur_idx;
		fill_wdata = fill_rd_q;
		lim_we     = 1'b0;
		ent_we     = 1'b0;
		ent_re     = 1'b0;
		alloc_inc  = 1'b0;
		if (state_q == S_EXEC) begin
			if ((cur_q.cmd != msec_pkg::CMD_ALLOC) && !id_ok) begin
				nx_status = msec_pkg::ST_NOT_ALLOC;
				nx_fill   = '0;
				nx_empty  = 1'b1;
			end else begin
				unique case (cur_q.cmd)
					msec_pkg::CMD_ALLOC: begin
						if (alloc_q == CNT_FULL) begin
							nx_status = msec_pkg::ST_NO_FREE;
							nx_id     = '0;
							nx_fill   = '0;
							nx_empty  = 1'b0;
						end else begin
							lim_we     = 1'b1;
							fill_we    = 1'b1;
							fill_waddr = alloc_idx;
							fill_wdata = '0;
							alloc_inc  = 1'b1;
							nx_id      = msec_pkg::ID_W'(alloc_q);
							nx_fill    = '0;
							nx_empty   = 1'b1;
						end
					end
					msec_pkg::CMD_PUSH: begin
						if (fill_rd_q >= lim_rd_q) begin
							nx_status = msec_pkg::ST_FULL;
						end else begin
							ent_we     = 1'b1;
							fill_we    = 1'b1;
							fill_wdata = fill_inc;
							nx_fill    = fill_inc;
							nx_empty   = 1'b0;
						end
					end
					msec_pkg::CMD_POP: begin
						if (fill_rd_q == '0) begin
							nx_status = msec_pkg::ST_EMPTY;
						end else begin
							ent_re     = 1'b1;
							fill_we    = 1'b1;
							fill_wdata = fill_dec;
							nx_fill    = fill_dec;
							nx_empty   = (fill_dec == '0);
						end
					end
					msec_pkg::CMD_QUERY: begin
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_q        <= '0;
			alloc_q      <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= msec_pkg::ST_OK;
			out_id_q     <= '0;
			out_pop_q    <= '0;
			out_fill_q   <= '0;
			out_empty_q  <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cur_q   <= q_item;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (alloc_inc) begin
						alloc_q <= alloc_q + 1'b1;
					end
					out_status_q <= nx_status;
					out_id_q     <= nx_id;
					out_pop_q    <= '0;
					out_fill_q   <= msec_pkg::FILL_OUT_W'(nx_fill);
					out_empty_q  <= nx_empty;
					if (ent_re) begin
						state_q <= S_POP;
					end else begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_POP: begin
					out_pop_q   <= msec_pkg::DATA_W'(ent_rd_q);
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// fill and limit entries are read for every request taken, but used only for stacks already allocated
	always_ff @(posedge clk) begin
		if (start) begin
			fill_rd_q <= fill_mem[rd_idx];
			lim_rd_q  <= lim_mem[rd_idx];
		end
		if (fill_we) begin
			fill_mem[fill_waddr] <= fill_wdata;
		end
		if (lim_we) begin
			lim_mem[alloc_idx] <= FILL_W'(cur_q.cap);
		end
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[addr_push] <= VALUE_WIDTH'(cur_q.value);
		end
		if (ent_re) begin
			ent_rd_q <= ent_mem[addr_pop];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{M_PAD{1'b0}}, out_empty_q, out_fill_q, out_pop_q, out_id_q};
	assign m_axis_tuser  = out_status_q;
endmodule

/* rtl/multi_stack_engine_core.sv */
// path: front register, request queue, back sequencer (fill/limit read, execute, and entry read
// for a successful pop), output register; the back sequencer handles one request at a time and
//   takes the next only when idle and its output register is free or being taken
// the front stage and a 2-entry queue keep taking requests while the back stage works
// reset: asynchronous, active low; clears control state and the allocation count
// entry, fill and limit memories are not cleared and their values are only used after being written
`timescale 1ns / 1ps
`include "assert_macros.svh"
module multi_stack_engine_core #(
	parameter int NUM_STACKS  = msec_pkg::NUM_STACKS_DEF,
	parameter int MAX_DEPTH   = msec_pkg::MAX_DEPTH_DEF,
	parameter int VALUE_WIDTH = msec_pkg::VALUE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [msec_pkg::S_TDATA_W-1:0] s_axis_tdata,  // stack_id, push_value, capacity
	input  logic [msec_pkg::CMD_W-1:0]     s_axis_tuser,  // cmd
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [msec_pkg::M_TDATA_W-1:0] m_axis_tdata,  // result_id, pop_value, fill_level, is_empty
	output logic [msec_pkg::STATUS_W-1:0]  m_axis_tuser   // status
);
	localparam int POP_LSB   = msec_pkg::ID_W;
	localparam int FILL_LSB  = POP_LSB + msec_pkg::DATA_W;
	localparam int EMPTY_BIT = FILL_LSB + msec_pkg::FILL_OUT_W;

	logic            fq_valid;
	logic            fq_ready;
	msec_pkg::item_t fq_item;
	logic            qb_valid;
	logic            qb_ready;
	msec_pkg::item_t qb_item;

	msec_front #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_valid       (fq_valid),
		.q_ready       (fq_ready),
		.q_item        (fq_item)
	);

	msec_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_item   (fq_item),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_item  (qb_item)
	);

	msec_back #(
		.NUM_STACKS  (NUM_STACKS),
		.MAX_DEPTH   (MAX_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (qb_valid),
		.q_ready       (qb_ready),
		.q_item        (qb_item),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	`ASSERT_IMPLIES(a_pop_value_zero_on_error, m_axis_tvalid && (m_axis_tuser != msec_pkg::ST_OK), m_axis_tdata[FILL_LSB-1:POP_LSB] == '0)
	`ASSERT_IMPLIES(a_empty_means_no_fill, m_axis_tvalid && m_axis_tdata[EMPTY_BIT], m_axis_tdata[EMPTY_BIT-1:FILL_LSB] == '0)
	`ASSERT_IMPLIES(a_not_alloc_reports_empty, m_axis_tvalid && (m_axis_tuser == msec_pkg::ST_NOT_ALLOC), m_axis_tdata[EMPTY_BIT])
	`ASSERT_NEVER(a_no_free_not_empty, m_axis_tvalid && (m_axis_tuser == msec_pkg::ST_NO_FREE) && m_axis_tdata[EMPTY_BIT])
endmodule

/* tb/sv/msec_result_checker.sv */
// result checker for the multi stack engine: watches both stream channels,
// keeps its own copy of the stack state and compares every result in order
// depends on: msec_pkg
`timescale 1ns / 1ps
module msec_result_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [msec_pkg::S_TDATA_W-1:0] s_tdata,  // stack_id, push_value, capacity
	input  logic [msec_pkg::CMD_W-1:0]     s_tuser,  // cmd
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [msec_pkg::M_TDATA_W-1:0] m_tdata,  // result_id, pop_value, fill_level, is_empty
	input  logic [msec_pkg::STATUS_W-1:0]  m_tuser,  // status
	output int                             fail_count,
	output int                             outstanding
);
	localparam int STORE_DEPTH = msec_pkg::NUM_STACKS_DEF * msec_pkg::MAX_DEPTH_DEF;
	localparam int SLOT_W      = $clog2(STORE_DEPTH);
	localparam int STK_W       = $clog2(msec_pkg::NUM_STACKS_DEF);

	typedef struct packed {
		msec_pkg::status_t                   status;
		logic [msec_pkg::ID_W-1:0]           id;
		logic [msec_pkg::DATA_W-1:0]         value;
		logic [msec_pkg::FILL_OUT_W-1:0]     fill;
		logic                                empty;
	} stack_result_t;

	logic [4:0]                      stacks_taken;
	logic [msec_pkg::FILL_OUT_W-1:0] stk_fill [msec_pkg::NUM_STACKS_DEF];
	logic [msec_pkg::FILL_OUT_W-1:0] stk_cap [msec_pkg::NUM_STACKS_DEF];
	logic [msec_pkg::DATA_W-1:0]     entry_mem [STORE_DEPTH];
	stack_result_t                   result_q [$];

	function automatic stack_result_t make_result(msec_pkg::status_t st,
			logic [msec_pkg::ID_W-1:0] id, logic [msec_pkg::DATA_W-1:0] val,
			logic [msec_pkg::FILL_OUT_W-1:0] fill, logic empty);
		stack_result_t r;
		r.status = st;
		r.id     = id;
		r.value  = val;
		r.fill   = fill;
		r.empty  = empty;
		return r;
	endfunction

	task automatic apply_request(input msec_pkg::cmd_t cmd, input logic [msec_pkg::ID_W-1:0] id,
			input logic [msec_pkg::DATA_W-1:0] val, input logic [msec_pkg::CAP_W-1:0] cap);
		logic [msec_pkg::FILL_OUT_W-1:0] fill;
		logic [SLOT_W-1:0]               slot;
		logic [STK_W-1:0]                new_idx;
		if (cmd == msec_pkg::CMD_ALLOC) begin
			if (stacks_taken >= msec_pkg::NUM_STACKS_DEF) begin
				result_q.push_back(make_result(msec_pkg::ST_NO_FREE, '0, '0, '0, 1'b0));
			end else begin
				new_idx = stacks_taken[STK_W-1:0];
				stk_cap[new_idx] = (cap > msec_pkg::MAX_DEPTH_DEF)
					? msec_pkg::FILL_OUT_W'(msec_pkg::MAX_DEPTH_DEF)
					: msec_pkg::FILL_OUT_W'(cap);
				stk_fill[new_idx] = '0;
				result_q.push_back(make_result(msec_pkg::ST_OK,
					stacks_taken[msec_pkg::ID_W-1:0], '0, '0, 1'b1));
				stacks_taken = stacks_taken + 1'b1;
			end
		end else if (id >= stacks_taken) begin
			result_q.push_back(make_result(msec_pkg::ST_NOT_ALLOC, id, '0, '0, 1'b1));
		end else begin
			fill = stk_fill[id];
			case (cmd)
				msec_pkg::CMD_PUSH: begin
					if (fill >= stk_cap[id]) begin
						result_q.push_back(make_result(msec_pkg::ST_FULL, id, '0, fill,
							fill == 0));
					end else begin
						slot = SLOT_W'(int'(id) * msec_pkg::MAX_DEPTH_DEF + int'(fill));
						entry_mem[slot] = val;
						fill = fill + 1'b1;
						stk_fill[id] = fill;
						result_q.push_back(make_result(msec_pkg::ST_OK, id, '0, fill, 1'b0));
					end
				end
				msec_pkg::CMD_POP: begin
					if (fill == 0) begin
						result_q.push_back(make_result(msec_pkg::ST_EMPTY, id, '0, '0, 1'b1));
					end else begin
						fill = fill - 1'b1;
						slot = SLOT_W'(int'(id) * msec_pkg::MAX_DEPTH_DEF + int'(fill));
						stk_fill[id] = fill;
						result_q.push_back(make_result(msec_pkg::ST_OK, id, entry_mem[slot],
							fill, fill == 0));
					end
				end
				default: begin
					result_q.push_back(make_result(msec_pkg::ST_OK, id, '0, fill, fill == 0));
				end
			endcase
		end
	endtask

	task automatic check_field(input string name, input logic [msec_pkg::DATA_W-1:0] exp_v,
			input logic [msec_pkg::DATA_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		stack_result_t exp_r;
		stack_result_t act_r;
		if (!arst_n) begin
			stacks_taken = '0;
			for (int i = 0; i < msec_pkg::NUM_STACKS_DEF; i++) begin
				stk_fill[i] = '0;
				stk_cap[i] = '0;
			end
			result_q.delete();
			fail_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				act_r = make_result(msec_pkg::status_t'(m_tuser), m_tdata[3:0], m_tdata[67:4],
					m_tdata[74:68], m_tdata[75]);
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %h %h",
						$time, m_tuser, m_tdata);
					fail_count++;
				end else begin
					exp_r = result_q.pop_front();
					check_field("status", msec_pkg::DATA_W'(exp_r.status),
						msec_pkg::DATA_W'(act_r.status));
					check_field("result_id", msec_pkg::DATA_W'(exp_r.id),
						msec_pkg::DATA_W'(act_r.id));
					check_field("pop_value", exp_r.value, act_r.value);
					check_field("fill_level", msec_pkg::DATA_W'(exp_r.fill),
						msec_pkg::DATA_W'(act_r.fill));
					check_field("is_empty", msec_pkg::DATA_W'(exp_r.empty),
						msec_pkg::DATA_W'(act_r.empty));
				end
			end
			if (s_tvalid && s_tready)
				apply_request(msec_pkg::cmd_t'(s_tuser), s_tdata[3:0], s_tdata[67:4],
					s_tdata[75:68]);
		end
		outstanding = result_q.size();
	end
endmodule

/* tb/sv/tb_multi_stack_engine_core.sv */
// testbench top for multi_stack_engine_core: directed and random stack requests
// with random idling and backpressure, checked by msec_result_checker
// depends on: msec_pkg, multi_stack_engine_core, msec_result_checker
`timescale 1ns / 1ps
module tb_multi_stack_engine_core;
	localparam int RANDOM_ITEMS = 820;
	localparam int CYCLE_LIMIT  = 200000;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [msec_pkg::S_TDATA_W-1:0] s_axis_tdata;  // stack_id, push_value, capacity
	logic [msec_pkg::CMD_W-1:0]     s_axis_tuser;  // cmd
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [msec_pkg::M_TDATA_W-1:0] m_axis_tdata;  // result_id, pop_value, fill_level, is_empty
	logic [msec_pkg::STATUS_W-1:0]  m_axis_tuser;  // status

	int fail_count;
	int outstanding;
	int items_sent = 0;
	int allocs_sent = 0;
	int cycle_count = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	multi_stack_engine_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	msec_result_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_axis_tvalid),
		.s_tready    (s_axis_tready),
		.s_tdata     (s_axis_tdata),
		.s_tuser     (s_axis_tuser),
		.m_tvalid    (m_axis_tvalid),
		.m_tready    (m_axis_tready),
		.m_tdata     (m_axis_tdata),
		.m_tuser     (m_axis_tuser),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("multi_stack_engine_core: mismatch");
			$finish;
		end
	end

	// no idling on either side in this stretch
	function automatic bit quiet_stretch();
		return items_sent >= 300 && items_sent < 450;
	endfunction

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (!hold_done && items_sent >= 500) begin
				hold_done = 1'b1;
				hold_left = 199;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= quiet_stretch() || ($urandom_range(0, 99) >= 12);
			end
		end
	end

	task automatic send_request(input msec_pkg::cmd_t cmd, input logic [msec_pkg::ID_W-1:0] id,
			input logic [msec_pkg::DATA_W-1:0] val, input logic [msec_pkg::CAP_W-1:0] cap);
		@(negedge clk);
		while (!quiet_stretch() && $urandom_range(0, 99) < 12) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		if (items_sent == 250 && outstanding != 0) begin
			s_axis_tvalid <= 1'b0;
			while (outstanding != 0)
				@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {4'b0, cap, val, id};
		do
			@(posedge clk);
		while (!s_axis_tready);
		items_sent++;
		if (cmd == msec_pkg::CMD_ALLOC)
			allocs_sent++;
	endtask

	function automatic logic [msec_pkg::DATA_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [msec_pkg::CAP_W-1:0] rand_capacity();
		if ($urandom_range(0, 3) == 0)
			return msec_pkg::CAP_W'($urandom_range(0, 255));
		return msec_pkg::CAP_W'($urandom_range(0, 80));
	endfunction

	function automatic logic [msec_pkg::CAP_W-1:0] any_capacity();
		return msec_pkg::CAP_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [msec_pkg::ID_W-1:0] rand_id();
		return msec_pkg::ID_W'($urandom_range(0, 15));
	endfunction

	function automatic logic [msec_pkg::ID_W-1:0] taken_stack();
		int top_id;
		top_id = (allocs_sent > msec_pkg::NUM_STACKS_DEF) ? msec_pkg::NUM_STACKS_DEF
			: allocs_sent;
		return msec_pkg::ID_W'($urandom_range(0, top_id - 1));
	endfunction

	initial begin
		int                        pick;
		int                        burst_len;
		logic [msec_pkg::ID_W-1:0] burst_id;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = msec_pkg::CMD_QUERY;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// unallocated stacks, zero capacity, saturated capacity, full and empty
		send_request(msec_pkg::CMD_QUERY, 4'd15, '0, '0);
		send_request(msec_pkg::CMD_PUSH, 4'd0, '1, '1);
		send_request(msec_pkg::CMD_POP, 4'd3, '0, '0);
		send_request(msec_pkg::CMD_ALLOC, 4'd0, '0, 8'd0);
		send_request(msec_pkg::CMD_PUSH, 4'd0, 64'h1234_5678_9abc_def0, '0);
		send_request(msec_pkg::CMD_POP, 4'd0, '0, '0);
		send_request(msec_pkg::CMD_QUERY, 4'd0, '0, '0);
		send_request(msec_pkg::CMD_ALLOC, 4'd7, '1, 8'd255);
		send_request(msec_pkg::CMD_PUSH, 4'd1, '0, '0);
		send_request(msec_pkg::CMD_PUSH, 4'd1, '1, '0);
		send_request(msec_pkg::CMD_QUERY, 4'd1, '0, '0);
		send_request(msec_pkg::CMD_POP, 4'd1, '0, '0);
		send_request(msec_pkg::CMD_POP, 4'd1, '0, '0);
		send_request(msec_pkg::CMD_POP, 4'd1, '0, '0);
		send_request(msec_pkg::CMD_ALLOC, 4'd0, '0, 8'd1);
		send_request(msec_pkg::CMD_PUSH, 4'd2, 64'ha5a5_a5a5_5a5a_5a5a, '0);
		send_request(msec_pkg::CMD_PUSH, 4'd2, 64'h5a5a_5a5a_a5a5_a5a5, '0);
		send_request(msec_pkg::CMD_POP, 4'd2, '0, '0);
		send_request(msec_pkg::CMD_ALLOC, 4'd0, '0, 8'd64);
		send_request(msec_pkg::CMD_ALLOC, 4'd0, '0, 8'd65);
		send_request(msec_pkg::CMD_QUERY, 4'd5, '0, '0);

		while (items_sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			burst_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 70)
				: $urandom_range(1, 16);
			burst_id = taken_stack();
			if (pick < 8) begin
				send_request(msec_pkg::CMD_ALLOC, rand_id(), rand_value(), rand_capacity());
			end else if (pick < 48) begin
				repeat (burst_len)
					send_request(msec_pkg::CMD_PUSH, burst_id, rand_value(), any_capacity());
			end else if (pick < 78) begin
				repeat (burst_len)
					send_request(msec_pkg::CMD_POP, burst_id, rand_value(), any_capacity());
			end else if (pick < 88) begin
				send_request(msec_pkg::CMD_QUERY, rand_id(), rand_value(), any_capacity());
			end else begin
				repeat ($urandom_range(1, 5))
					send_request(msec_pkg::cmd_t'($urandom_range(0, 3)), rand_id(),
						rand_value(), any_capacity());
			end
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("multi_stack_engine_core: match");
		else
			$display("multi_stack_engine_core: mismatch");
		$finish;
	end
endmodule
